[src/rom_tape_pulse_encoder_unit_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the tape pulse encoder
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ROM_TAPE_PULSE_ENCODER_UNIT_ASSERT_SVH
`define ROM_TAPE_PULSE_ENCODER_UNIT_ASSERT_SVH

// same-cycle implication
`define RTPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtpe check failed");

// next-cycle implication
`define RTPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtpe check failed");

`endif

[src/rtpe_pkg.sv]
// ---------------------------------------------------------------------------
// rtpe_pkg
// Shared types and constants of the tape pulse encoder.
// ---------------------------------------------------------------------------
package rtpe_pkg;

  localparam int NUM_SLOTS = 20;
  localparam int SLOT_W    = 5;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_TONE  = 2'd1;
  localparam logic [1:0] CMD_PAUSE = 2'd2;

  localparam logic [2:0] REG_ZERO_PULSES     = 3'd0;
  localparam logic [2:0] REG_ONE_PULSES      = 3'd1;
  localparam logic [2:0] REG_BYTE_END_PULSES = 3'd2;
  localparam logic [2:0] REG_DATA_END_PULSES = 3'd3;
  localparam logic [2:0] REG_PARITY_MODE     = 3'd4;
  localparam logic [2:0] REG_MSB_FIRST       = 3'd5;
  localparam logic [2:0] REG_FINAL_BYTE_BITS = 3'd6;

  localparam logic [1:0] PARITY_EVEN = 2'd0;
  localparam logic [1:0] PARITY_ODD  = 2'd1;
  localparam logic [1:0] PARITY_NONE = 2'd2;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [9:0] US_PER_MS     = 10'd1000;

  localparam logic [SLOT_W-1:0] SLOT_PARITY = 5'd16;
  localparam logic [SLOT_W-1:0] SLOT_END    = 5'd18;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_TONE,
    KIND_PAUSE
  } kind_t;

  typedef struct packed {
    logic [15:0] zero_pulses;
    logic [15:0] one_pulses;
    logic [15:0] byte_end_pulses;
    logic [15:0] data_end_pulses;
    logic [1:0]  parity_mode;
    logic        msb_first;
    logic [3:0]  final_byte_bits;
  } cfg_t;

  // payload: data bits in send order, tone width, or pause length in us
  typedef struct packed {
    kind_t                 kind;
    logic                  final_byte;
    logic                  parity;
    logic [23:0]           payload;
    logic [NUM_SLOTS-1:0]  mask;
  } job_t;

endpackage

[src/rtpe_front.sv]
// ---------------------------------------------------------------------------
// rtpe_front
// Classifies an input word into a job: slot mask, send order, parity.
// ---------------------------------------------------------------------------
module rtpe_front (
  input  logic              in_push,
  input  logic              in_full,
  input  logic [1:0]        in_command,
  input  logic [15:0]       in_value,
  input  logic              in_final_byte,
  input  rtpe_pkg::cfg_t    cfg,
  output logic              job_push,
  output rtpe_pkg::job_t    job
);

  logic [7:0]  src_byte;
  logic [7:0]  ordered;
  logic [3:0]  nbits;
  logic [7:0]  in_range;
  logic        parity;
  logic [15:0] par_pair;
  logic [15:0] end_pair;
  logic [15:0] bit_pair;
  logic [25:0] us_full;

  always_comb begin
    src_byte = in_value[7:0];
    for (int i = 0; i < 8; i++) begin
      ordered[i] = cfg.msb_first ? src_byte[7-i] : src_byte[i];
    end
    if (in_final_byte) begin
      nbits = (cfg.final_byte_bits > rtpe_pkg::BITS_PER_BYTE) ?
              rtpe_pkg::BITS_PER_BYTE : cfg.final_byte_bits;
    end else begin
      nbits = rtpe_pkg::BITS_PER_BYTE;
    end
    for (int i = 0; i < 8; i++) begin
      in_range[i] = (4'(i) < nbits);
    end
    parity   = (cfg.parity_mode == rtpe_pkg::PARITY_ODD) ^ (^(ordered & in_range));
    par_pair = parity ? cfg.one_pulses : cfg.zero_pulses;
    end_pair = in_final_byte ? cfg.data_end_pulses : cfg.byte_end_pulses;
    us_full  = 26'(in_value) * 26'(rtpe_pkg::US_PER_MS);
    bit_pair = '0;

    job      = '0;
    job.kind = rtpe_pkg::KIND_DATA;
    job.final_byte = in_final_byte;
    job.parity     = parity;
    case (in_command)
      rtpe_pkg::CMD_DATA: begin
        job.kind         = rtpe_pkg::KIND_DATA;
        job.payload[7:0] = ordered;
        for (int i = 0; i < 8; i++) begin
          bit_pair = ordered[i] ? cfg.one_pulses : cfg.zero_pulses;
          job.mask[2*i]   = in_range[i] && (bit_pair[7:0] != 8'd0);
          job.mask[2*i+1] = in_range[i] && (bit_pair[15:8] != 8'd0);
        end
        if (cfg.parity_mode == rtpe_pkg::PARITY_EVEN ||
            cfg.parity_mode == rtpe_pkg::PARITY_ODD) begin
          job.mask[rtpe_pkg::SLOT_PARITY]      = (par_pair[7:0] != 8'd0);
          job.mask[rtpe_pkg::SLOT_PARITY + 1]  = (par_pair[15:8] != 8'd0);
        end
        job.mask[rtpe_pkg::SLOT_END]     = (end_pair[7:0] != 8'd0);
        job.mask[rtpe_pkg::SLOT_END + 1] = (end_pair[15:8] != 8'd0);
      end
      rtpe_pkg::CMD_TONE: begin
        job.kind         = rtpe_pkg::KIND_TONE;
        job.payload[7:0] = src_byte;
        job.mask[0]      = 1'b1;
      end
      rtpe_pkg::CMD_PAUSE: begin
        job.kind      = rtpe_pkg::KIND_PAUSE;
        job.payload   = us_full[23:0];
        job.mask[3:0] = 4'hf;
      end
      default: begin
        job.mask = '0;
      end
    endcase
  end

  // words that yield no pulses never enter the queue
  assign job_push = in_push && !in_full && (job.mask != '0);

endmodule

[src/rtpe_queue.sv]
// ---------------------------------------------------------------------------
// rtpe_queue
// Small job queue between the classifier and the pulse sequencer.
// ---------------------------------------------------------------------------
`include "rom_tape_pulse_encoder_unit_assert.svh"

module rtpe_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rtpe_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output rtpe_pkg::job_t  head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtpe_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  `RTPE_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `RTPE_ASSERT_NEXT(a_push_only_grows, do_push && !do_pop, count_r == $past(count_r) + 1'b1)
  `RTPE_ASSERT_SAME(a_ptr_match, count_r == '0 || count_r == CNT_W'(DEPTH),
                    wr_ptr_r == rd_ptr_r)

endmodule

[src/rtpe_back.sv]
// ---------------------------------------------------------------------------
// rtpe_back
// Pulse sequencer: walks the live slots of a job, one pulse word a cycle while output has room.
// ---------------------------------------------------------------------------
`include "rom_tape_pulse_encoder_unit_assert.svh"

module rtpe_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rtpe_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  rtpe_pkg::job_t  q_job,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [7:0]      out_pulse,
  output logic            out_last_of_run
);

  rtpe_pkg::job_t                  job_r, job_nxt;
  logic                            cur_valid_r, cur_valid_nxt;
  logic [rtpe_pkg::NUM_SLOTS-1:0]  rem_r, rem_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      pulse_r, pulse_nxt;
  logic                            last_r, last_nxt;

  logic [rtpe_pkg::NUM_SLOTS-1:0]  pick;
  logic [rtpe_pkg::NUM_SLOTS-1:0]  rem_left;
  logic [rtpe_pkg::SLOT_W-1:0]     idx;
  logic [15:0]                     pair;
  logic [7:0]                      width;
  logic                            out_room;
  logic                            advance;
  logic                            run_done;

  // lowest live slot
  always_comb begin
    pick     = rem_r & (~rem_r + 1'b1);
    rem_left = rem_r & ~pick;
    idx      = '0;
    for (int i = 0; i < rtpe_pkg::NUM_SLOTS; i++) begin
      if (pick[i]) begin
        idx = idx | rtpe_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    pair  = '0;
    width = '0;
    case (job_r.kind)
      rtpe_pkg::KIND_DATA: begin
        if (idx < rtpe_pkg::SLOT_PARITY) begin
          pair = job_r.payload[{2'b00, idx[3:1]}] ? cfg.one_pulses : cfg.zero_pulses;
        end else if (idx < rtpe_pkg::SLOT_END) begin
          pair = job_r.parity ? cfg.one_pulses : cfg.zero_pulses;
        end else begin
          pair = job_r.final_byte ? cfg.data_end_pulses : cfg.byte_end_pulses;
        end
        width = idx[0] ? pair[15:8] : pair[7:0];
      end
      rtpe_pkg::KIND_TONE: begin
        width = job_r.payload[7:0];
      end
      rtpe_pkg::KIND_PAUSE: begin
        case (idx[1:0])
          2'd0:    width = 8'd0;
          2'd1:    width = job_r.payload[7:0];
          2'd2:    width = job_r.payload[15:8];
          2'd3:    width = job_r.payload[23:16];
          default: width = 8'd0;
        endcase
      end
      default: begin
        width = 8'd0;
      end
    endcase
  end

  assign out_room = !out_valid_r || out_pop;
  assign advance  = cur_valid_r && out_room;
  assign run_done = advance && (rem_left == '0);
  assign q_pop    = !q_empty && (!cur_valid_r || run_done);

  always_comb begin
    job_nxt       = job_r;
    rem_nxt       = rem_r;
    cur_valid_nxt = cur_valid_r;
    out_valid_nxt = out_valid_r;
    pulse_nxt     = pulse_r;
    last_nxt      = last_r;
    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
    if (advance) begin
      out_valid_nxt = 1'b1;
      pulse_nxt     = width;
      last_nxt      = (rem_left == '0);
      rem_nxt       = rem_left;
      if (rem_left == '0) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      job_nxt       = q_job;
      rem_nxt       = q_job.mask;
      cur_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    rem_r   <= rem_nxt;
    pulse_r <= pulse_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty       = !out_valid_r;
  assign out_pulse       = pulse_r;
  assign out_last_of_run = last_r;

  `RTPE_ASSERT_SAME(a_live_job_has_slots, cur_valid_r, rem_r != '0)
  `RTPE_ASSERT_SAME(a_pick_onehot, cur_valid_r, $onehot(pick))
  `RTPE_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r)
  `RTPE_ASSERT_SAME(a_pop_not_empty, q_pop, !q_empty)

endmodule

[src/rom_tape_pulse_encoder_unit.sv]
// An accepted item passes the job queue and the sequencer's job register before its
// first pulse word is registered onto the result ports. The sequencer gives one pulse
// word per cycle while the output has room; a data byte has up to 20, tone 1, pause 4.
// Input is taken every cycle while the job queue has room.
// Reset (synchronous, rst_n low) empties queue and output and loads register defaults.
// ---------------------------------------------------------------------------
// rom_tape_pulse_encoder_unit
// Tape pulse-width encoder: config registers, classifier, job queue, sequencer.
// ---------------------------------------------------------------------------
module rom_tape_pulse_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_value,
  input  logic        in_final_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_pulse,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rtpe_pkg::cfg_t cfg_r, cfg_nxt;
  rtpe_pkg::job_t front_job;
  rtpe_pkg::job_t head_job;
  logic           job_push;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rtpe_pkg::REG_ZERO_PULSES:     cfg_nxt.zero_pulses     = cfg_data;
        rtpe_pkg::REG_ONE_PULSES:      cfg_nxt.one_pulses      = cfg_data;
        rtpe_pkg::REG_BYTE_END_PULSES: cfg_nxt.byte_end_pulses = cfg_data;
        rtpe_pkg::REG_DATA_END_PULSES: cfg_nxt.data_end_pulses = cfg_data;
        rtpe_pkg::REG_PARITY_MODE:     cfg_nxt.parity_mode     = cfg_data[1:0];
        rtpe_pkg::REG_MSB_FIRST:       cfg_nxt.msb_first       = cfg_data[0];
        rtpe_pkg::REG_FINAL_BYTE_BITS: cfg_nxt.final_byte_bits = cfg_data[3:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero_pulses     <= '0;
      cfg_r.one_pulses      <= '0;
      cfg_r.byte_end_pulses <= '0;
      cfg_r.data_end_pulses <= '0;
      cfg_r.parity_mode     <= rtpe_pkg::PARITY_NONE;
      cfg_r.msb_first       <= 1'b0;
      cfg_r.final_byte_bits <= rtpe_pkg::BITS_PER_BYTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rtpe_front u_front (
    .in_push       (in_push),
    .in_full       (in_full),
    .in_command    (in_command),
    .in_value      (in_value),
    .in_final_byte (in_final_byte),
    .cfg           (cfg_r),
    .job_push      (job_push),
    .job           (front_job)
  );

  rtpe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (front_job),
    .full     (in_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (head_job)
  );

  rtpe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_empty         (q_empty),
    .q_job           (head_job),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pulse       (out_pulse),
    .out_last_of_run (out_last_of_run)
  );

endmodule

[dv/pulse_stream_checker.sv]
// ---------------------------------------------------------------------------
// pulse_stream_checker
// Watches the config, input and result channels of the tape pulse encoder.
// Keeps its own register copy and predicts the pulse words of every accepted
// input word. Each popped pulse word is compared against the oldest predicted one.
// ---------------------------------------------------------------------------
module pulse_stream_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_value,
  input  logic        in_final_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_pulse,
  input  logic        out_last_of_run,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pulses_owed,
  output int          mismatch_count
);

  localparam int MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] pulse;
    logic       last_of_run;
  } pulse_word_t;

  rtpe_pkg::cfg_t regs;
  pulse_word_t    expected_pulses [$];
  int             errors = 0;

  // zero widths in a pair are dropped
  function automatic void add_pair(input logic [15:0] pair);
    if (pair[7:0] != 8'h00) expected_pulses.push_back({pair[7:0], 1'b0});
    if (pair[15:8] != 8'h00) expected_pulses.push_back({pair[15:8], 1'b0});
  endfunction

  task automatic predict_pulses(input logic [1:0] cmd, input logic [15:0] val,
                                input logic fin);
    int          first;
    int          nbits;
    logic        parity;
    logic        b;
    logic [23:0] us;
    pulse_word_t tail;
    first = expected_pulses.size();
    case (cmd)
      rtpe_pkg::CMD_DATA: begin
        nbits = rtpe_pkg::BITS_PER_BYTE;
        if (fin) begin
          nbits = (regs.final_byte_bits > rtpe_pkg::BITS_PER_BYTE) ?
                  rtpe_pkg::BITS_PER_BYTE : regs.final_byte_bits;
        end
        parity = (regs.parity_mode == rtpe_pkg::PARITY_ODD);
        for (int i = 0; i < nbits; i++) begin
          b = regs.msb_first ? val[7 - i] : val[i];
          parity ^= b;
          add_pair(b ? regs.one_pulses : regs.zero_pulses);
        end
        if (regs.parity_mode == rtpe_pkg::PARITY_EVEN ||
            regs.parity_mode == rtpe_pkg::PARITY_ODD) begin
          add_pair(parity ? regs.one_pulses : regs.zero_pulses);
        end
        add_pair(fin ? regs.data_end_pulses : regs.byte_end_pulses);
      end
      rtpe_pkg::CMD_TONE: expected_pulses.push_back({val[7:0], 1'b0});
      rtpe_pkg::CMD_PAUSE: begin
        us = 24'(32'(val) * 32'(rtpe_pkg::US_PER_MS));
        expected_pulses.push_back({8'h00, 1'b0});
        expected_pulses.push_back({us[7:0], 1'b0});
        expected_pulses.push_back({us[15:8], 1'b0});
        expected_pulses.push_back({us[23:16], 1'b0});
      end
      default: ;
    endcase
    if (expected_pulses.size() > first) begin
      tail = expected_pulses.pop_back();
      tail.last_of_run = 1'b1;
      expected_pulses.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    pulse_word_t want;
    if (!rst_n) begin
      regs = '{zero_pulses: 16'h0000, one_pulses: 16'h0000, byte_end_pulses: 16'h0000,
               data_end_pulses: 16'h0000, parity_mode: rtpe_pkg::PARITY_NONE,
               msb_first: 1'b0, final_byte_bits: rtpe_pkg::BITS_PER_BYTE};
      expected_pulses.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rtpe_pkg::REG_ZERO_PULSES:     regs.zero_pulses = cfg_data;
          rtpe_pkg::REG_ONE_PULSES:      regs.one_pulses = cfg_data;
          rtpe_pkg::REG_BYTE_END_PULSES: regs.byte_end_pulses = cfg_data;
          rtpe_pkg::REG_DATA_END_PULSES: regs.data_end_pulses = cfg_data;
          rtpe_pkg::REG_PARITY_MODE:     regs.parity_mode = cfg_data[1:0];
          rtpe_pkg::REG_MSB_FIRST:       regs.msb_first = cfg_data[0];
          rtpe_pkg::REG_FINAL_BYTE_BITS: regs.final_byte_bits = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_push && !in_full) predict_pulses(in_command, in_value, in_final_byte);
      if (out_pop && !out_empty) begin
        if (expected_pulses.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS) begin
            $display("%0t: unexpected pulse word %0d last %0b", $time, out_pulse,
                     out_last_of_run);
          end
        end else begin
          want = expected_pulses.pop_front();
          if (out_pulse !== want.pulse || out_last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: pulse word expected %0d last %0b, actual %0d last %0b",
                       $time, want.pulse, want.last_of_run, out_pulse, out_last_of_run);
            end
          end
        end
      end
    end
    pulses_owed    <= expected_pulses.size();
    mismatch_count <= errors;
  end

endmodule

[dv/tb_rom_tape_pulse_encoder_unit.sv]
// ---------------------------------------------------------------------------
// tb_rom_tape_pulse_encoder_unit
// Drives the tape pulse encoder with directed and random data, tone, pause
// and stray words across several register setups, with random idling on both
// sides and one long output stall. A side checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_rom_tape_pulse_encoder_unit;

  localparam logic [1:0] CMD_IGNORED   = 2'd3;
  localparam logic [1:0] PARITY_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 45;
  localparam int RANDOM_PHASES   = 6;
  localparam int SETTLE_CYCLES   = 50;
  localparam int HOLD_CYCLES     = 400;
  localparam int STALL_LIMIT     = 2000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_command = rtpe_pkg::CMD_DATA;
  logic [15:0] in_value = 16'h0000;
  logic        in_final_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_pulse;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = rtpe_pkg::REG_ZERO_PULSES;
  logic [15:0] cfg_data = 16'h0000;
  int          pulses_owed;
  int          mismatch_count;
  int          hold_asks = 0;
  logic        no_idle = 1'b0;

  rom_tape_pulse_encoder_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_final_byte   (in_final_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pulse       (out_pulse),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  pulse_stream_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_value        (in_value),
    .in_final_byte   (in_final_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_pulse       (out_pulse),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pulses_owed     (pulses_owed),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [15:0] random_pair();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'h00, 8'($urandom_range(1, 255))};
      3: return {8'($urandom_range(1, 255)), 8'h00};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [15:0] val,
                           input logic fin);
    int gap;
    in_push       <= 1'b1;
    in_command    <= cmd;
    in_value      <= val;
    in_final_byte <= fin;
    do @(posedge clk); while (in_full);
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // leaves cfg_valid high; load_regs drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_regs(input rtpe_pkg::cfg_t c);
    write_reg(rtpe_pkg::REG_ZERO_PULSES, c.zero_pulses);
    write_reg(rtpe_pkg::REG_ONE_PULSES, c.one_pulses);
    write_reg(rtpe_pkg::REG_BYTE_END_PULSES, c.byte_end_pulses);
    write_reg(rtpe_pkg::REG_DATA_END_PULSES, c.data_end_pulses);
    write_reg(rtpe_pkg::REG_PARITY_MODE, {14'h0000, c.parity_mode});
    write_reg(rtpe_pkg::REG_MSB_FIRST, {15'h0000, c.msb_first});
    write_reg(rtpe_pkg::REG_FINAL_BYTE_BITS, {12'h000, c.final_byte_bits});
    cfg_valid <= 1'b0;
  endtask

  // empty runs leave no trace, so give the block time to finish them
  task automatic settle();
    in_push <= 1'b0;
    do @(posedge clk); while (pulses_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int run_len;
    int gap;
    int holds_done;
    holds_done = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_pop <= 1'b1;
      run_len = ($urandom_range(0, 6) == 0) ? $urandom_range(50, 200)
                                            : $urandom_range(1, 30);
      repeat (run_len) @(posedge clk);
      gap = idle_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) ||
          (cfg_valid && cfg_ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("FAIL rom_tape_pulse_encoder_unit");
    $finish;
  end

  initial begin : stimulus
    rtpe_pkg::cfg_t setup;
    int             words;
    int             pick;
    int             blk_len;
    logic           fin;
    logic [15:0]    pause_ms;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset widths are all zero: data words give empty runs
    send_word(rtpe_pkg::CMD_TONE, 16'h0000, 1'b0);
    send_word(rtpe_pkg::CMD_TONE, 16'hFFFF, 1'b1);
    send_word(rtpe_pkg::CMD_PAUSE, 16'h0000, 1'b0);
    send_word(rtpe_pkg::CMD_PAUSE, 16'hFFFF, 1'b0);
    send_word(rtpe_pkg::CMD_PAUSE, 16'd16, 1'b1);
    send_word(CMD_IGNORED, 16'hA5A5, 1'b1);
    send_word(rtpe_pkg::CMD_DATA, 16'h00FF, 1'b1);
    settle();

    load_regs('{zero_pulses: 16'h0A05, one_pulses: 16'h1408, byte_end_pulses: 16'h00FF,
                data_end_pulses: 16'hFF00, parity_mode: rtpe_pkg::PARITY_EVEN,
                msb_first: 1'b0, final_byte_bits: rtpe_pkg::BITS_PER_BYTE});
    send_word(rtpe_pkg::CMD_DATA, 16'h0000, 1'b0);
    send_word(rtpe_pkg::CMD_DATA, 16'h00FF, 1'b0);
    send_word(rtpe_pkg::CMD_DATA, 16'h00A5, 1'b0);
    send_word(rtpe_pkg::CMD_DATA, 16'hFF3C, 1'b1);
    send_word(rtpe_pkg::CMD_TONE, 16'h0080, 1'b0);
    send_word(rtpe_pkg::CMD_DATA, 16'h005A, 1'b1);
    settle();

    // final byte with no bits
    load_regs('{zero_pulses: 16'hFFFF, one_pulses: 16'h0001, byte_end_pulses: 16'hFFFF,
                data_end_pulses: 16'h0000, parity_mode: rtpe_pkg::PARITY_ODD,
                msb_first: 1'b1, final_byte_bits: 4'h0});
    send_word(rtpe_pkg::CMD_DATA, 16'h0081, 1'b1);
    send_word(rtpe_pkg::CMD_DATA, 16'h0081, 1'b0);
    settle();

    // reserved parity mode, bit count saturates
    load_regs('{zero_pulses: 16'h0100, one_pulses: 16'h00FE, byte_end_pulses: 16'h0000,
                data_end_pulses: 16'h0707, parity_mode: PARITY_UNUSED, msb_first: 1'b0,
                final_byte_bits: 4'hF});
    send_word(rtpe_pkg::CMD_DATA, 16'h005A, 1'b1);
    send_word(rtpe_pkg::CMD_DATA, 16'h00C3, 1'b0);
    settle();

    load_regs('{zero_pulses: 16'hFFFF, one_pulses: 16'h0000, byte_end_pulses: 16'hFF01,
                data_end_pulses: 16'hFFFF, parity_mode: rtpe_pkg::PARITY_EVEN,
                msb_first: 1'b1, final_byte_bits: 4'h1});
    send_word(rtpe_pkg::CMD_DATA, 16'h0001, 1'b1);
    send_word(rtpe_pkg::CMD_DATA, 16'h0080, 1'b1);
    send_word(rtpe_pkg::CMD_DATA, 16'h0000, 1'b0);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      setup.zero_pulses     = random_pair();
      setup.one_pulses      = random_pair();
      setup.byte_end_pulses = random_pair();
      setup.data_end_pulses = random_pair();
      setup.parity_mode     = 2'($urandom_range(0, 3));
      setup.msb_first       = 1'($urandom_range(0, 1));
      setup.final_byte_bits = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                          : 4'($urandom_range(1, 8));
      load_regs(setup);
      no_idle = (phase == 3);
      if (phase == 1) hold_asks <= hold_asks + 1;
      words = 0;
      while (words < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          // a block of bytes ending in its final byte; now and then a flag is flipped
          blk_len = $urandom_range(1, 6);
          for (int b = 0; b < blk_len; b++) begin
            fin = (b == blk_len - 1);
            if ($urandom_range(0, 19) == 0) fin = ~fin;
            send_word(rtpe_pkg::CMD_DATA, 16'($urandom_range(0, 65535)), fin);
          end
          words += blk_len;
        end else if (pick < 82) begin
          send_word(rtpe_pkg::CMD_TONE, 16'($urandom_range(0, 65535)),
                    1'($urandom_range(0, 1)));
          words++;
        end else if (pick < 94) begin
          case ($urandom_range(0, 3))
            0: pause_ms = 16'($urandom_range(0, 20));
            1: pause_ms = 16'($urandom_range(16700, 16800));
            default: pause_ms = 16'($urandom_range(0, 65535));
          endcase
          send_word(rtpe_pkg::CMD_PAUSE, pause_ms, 1'($urandom_range(0, 1)));
          words++;
        end else begin
          send_word(CMD_IGNORED, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
        end
      end
      settle();
    end

    if (mismatch_count == 0 && pulses_owed == 0) begin
      $display("PASS rom_tape_pulse_encoder_unit");
    end else begin
      $display("FAIL rom_tape_pulse_encoder_unit");
    end
    $finish;
  end

endmodule

[rom_tape_pulse_encoder_unit.f]
+incdir+src
src/rtpe_pkg.sv
src/rtpe_front.sv
src/rtpe_queue.sv
src/rtpe_back.sv
src/rom_tape_pulse_encoder_unit.sv
dv/pulse_stream_checker.sv
dv/tb_rom_tape_pulse_encoder_unit.sv
